// ===== design/audio_noise_gate_core_assert.svh =====
// Assertion macros shared by the noise gate design.
`ifndef AUDIO_NOISE_GATE_CORE_ASSERT_SVH
`define AUDIO_NOISE_GATE_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define ANG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A trigger that must be followed by a condition on the next clock edge.
`define ANG_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== design/ang_pkg.sv =====
package ang_pkg;

  // Field widths.
  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_LIMIT  = 1000;
  localparam int MAX_CHANNELS = 8;

  localparam int THRESH_W = 15;
  localparam int HOLD_W   = 10;
  localparam int FRAMES_W = 17;
  localparam int GAIN_W   = 17;
  localparam int CH_CNT_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Q1.16 gain.
  localparam int GAIN_FRAC = 16;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << GAIN_FRAC);

  // Derived widths.
  localparam int MAG_W      = SAMPLE_WIDTH + 1;
  localparam int THR_CMP_W  = (MAG_W > THRESH_W) ? MAG_W : THRESH_W;
  localparam int LEVEL_W    = $clog2(COUNT_LIMIT + 1) + 1;
  localparam int LVL_CMP_W  = ((LEVEL_W > HOLD_W + 1) ? LEVEL_W : HOLD_W + 1) + 1;
  localparam int CH_POS_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_CMP_W   = ((CH_CNT_W > CH_POS_W) ? CH_CNT_W : CH_POS_W) + 2;
  localparam int PROD_W     = SAMPLE_WIDTH + GAIN_W + 1;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(COUNT_LIMIT);
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -LEVEL_W'(COUNT_LIMIT);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD     = 3'd0,
    REG_HOLD_COUNT    = 3'd1,
    REG_ATTACK_FRAMES = 3'd2,
    REG_ATTACK_STEP   = 3'd3,
    REG_DECAY_FRAMES  = 3'd4,
    REG_DECAY_STEP    = 3'd5,
    REG_CHANNEL_COUNT = 3'd6
  } ang_reg_e_t;

  // Gate phase codes.
  typedef enum logic [1:0] {
    PH_CLOSED  = 2'd0,
    PH_OPENING = 2'd1,
    PH_OPEN    = 2'd2,
    PH_CLOSING = 2'd3
  } ang_phase_t;

  // Configuration settings as one bundle.
  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [HOLD_W-1:0]   hold_count;
    logic [FRAMES_W-1:0] attack_frames;
    logic [GAIN_W-1:0]   attack_step;
    logic [FRAMES_W-1:0] decay_frames;
    logic [GAIN_W-1:0]   decay_step;
    logic [CH_CNT_W-1:0] channel_count;
  } ang_cfg_t;

  // Contents of the register between the gate update and the scaler.
  typedef struct packed {
    logic                           valid;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [GAIN_W-1:0]              gain;
    ang_phase_t                     phase;
  } ang_stage_t;

endpackage

// ===== design/audio_noise_gate_core.sv =====
// Channel   Direction  Handshake            Payload
// in        in         in_valid / in_stall  sample_in
// out       out        out_valid / out_stall sample_out, gate_phase
// cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per cycle is accepted while the input is not stalled; each result passes the stage and output registers.
// The gate update register feeds a single 16 x 18 multiply into the output register.
// Reset is synchronous and active high; it restores the register defaults and closes the gate.
// A stalled output holds its result while the stage register still takes one more request.
// Configuration writes are always ready.
module audio_noise_gate_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [ang_pkg::SAMPLE_WIDTH-1:0] sample_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ang_pkg::SAMPLE_WIDTH-1:0] sample_out,
  output logic [1:0]                              gate_phase,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ang_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [ang_pkg::CFG_DATA_W-1:0]          cfg_data
);

  `include "audio_noise_gate_core_assert.svh"

  ang_pkg::ang_cfg_t   cfg;
  ang_pkg::ang_stage_t stage;
  logic                down_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  ang_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Gate state and the stage register.
  ang_gate_ctrl u_gate_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .down_ready (down_ready),
    .stage      (stage)
  );

  // Gain multiply and output register.
  ang_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .ready      (down_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .gate_phase (gate_phase)
  );

  // A settled gate carries exactly zero or unity gain.
  `ANG_ASSERT_ALWAYS(a_closed_gain, !(stage.valid && stage.phase == ang_pkg::PH_CLOSED) || stage.gain == '0, "closed gate with nonzero gain")
  `ANG_ASSERT_ALWAYS(a_open_gain, !(stage.valid && stage.phase == ang_pkg::PH_OPEN) || stage.gain == ang_pkg::UNITY_GAIN, "open gate without unity gain")
  // Input is only held off while the stage register is full.
  `ANG_ASSERT_ALWAYS(a_stall_full, !in_stall || stage.valid, "input stalled with empty stage")
  // A stage request blocked by the output is kept.
  `ANG_ASSERT_NEXT(a_stage_hold, stage.valid && !down_ready, stage.valid, "stage request dropped while blocked")

endmodule

// ===== design/ang_cfg_regs.sv =====
module ang_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [ang_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [ang_pkg::CFG_DATA_W-1:0]  wr_data,
  output ang_pkg::ang_cfg_t               cfg
);

  // Register file; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= '0;
      cfg.hold_count    <= ang_pkg::HOLD_W'(480);
      cfg.attack_frames <= ang_pkg::FRAMES_W'(1);
      cfg.attack_step   <= ang_pkg::UNITY_GAIN;
      cfg.decay_frames  <= ang_pkg::FRAMES_W'(1);
      cfg.decay_step    <= ang_pkg::UNITY_GAIN;
      cfg.channel_count <= ang_pkg::CH_CNT_W'(2);
    end else if (wr_en) begin
      unique case (ang_pkg::ang_reg_e_t'(wr_index))
        ang_pkg::REG_THRESHOLD:     cfg.threshold     <= wr_data[ang_pkg::THRESH_W-1:0];
        ang_pkg::REG_HOLD_COUNT:    cfg.hold_count    <= wr_data[ang_pkg::HOLD_W-1:0];
        ang_pkg::REG_ATTACK_FRAMES: cfg.attack_frames <= wr_data[ang_pkg::FRAMES_W-1:0];
        ang_pkg::REG_ATTACK_STEP:   cfg.attack_step   <= wr_data[ang_pkg::GAIN_W-1:0];
        ang_pkg::REG_DECAY_FRAMES:  cfg.decay_frames  <= wr_data[ang_pkg::FRAMES_W-1:0];
        ang_pkg::REG_DECAY_STEP:    cfg.decay_step    <= wr_data[ang_pkg::GAIN_W-1:0];
        ang_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= wr_data[ang_pkg::CH_CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ang_gate_ctrl.sv =====
module ang_gate_ctrl (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ang_pkg::ang_cfg_t                      cfg,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ang_pkg::SAMPLE_WIDTH-1:0] sample_in,
  input  logic                                   down_ready,
  output ang_pkg::ang_stage_t                    stage
);

  ang_pkg::ang_phase_t                    phase, phase_next;
  logic signed [ang_pkg::LEVEL_W-1:0]     level_count, level_next;
  logic [ang_pkg::GAIN_W-1:0]             gain, gain_next;
  logic [ang_pkg::FRAMES_W-1:0]           ramp_left, ramp_next;
  logic [ang_pkg::CH_POS_W-1:0]           channel_pos, channel_pos_next;

  logic                                   accept;
  logic [ang_pkg::MAG_W-1:0]              mag;
  logic                                   above;
  logic [ang_pkg::GAIN_W:0]               gain_sum;
  logic signed [ang_pkg::LVL_CMP_W-1:0]   level_ext;
  logic signed [ang_pkg::LVL_CMP_W-1:0]   hold_ext;
  logic [ang_pkg::CH_CMP_W-1:0]           chans;
  logic [ang_pkg::CH_CMP_W-1:0]           pos_inc;

  // The stage register takes a new request when empty or when it drains.
  assign in_stall = stage.valid && !down_ready;
  assign accept   = in_valid && !in_stall;

  // Magnitude is one bit wider so the most negative sample is exact.
  always_comb begin
    mag = sample_in[ang_pkg::SAMPLE_WIDTH-1]
        ? ang_pkg::MAG_W'(-{sample_in[ang_pkg::SAMPLE_WIDTH-1], sample_in})
        : ang_pkg::MAG_W'({sample_in[ang_pkg::SAMPLE_WIDTH-1], sample_in});
    above = ang_pkg::THR_CMP_W'(mag) > ang_pkg::THR_CMP_W'(cfg.threshold);
  end

  // Per-frame gate update.
  always_comb begin
    phase_next = phase;
    level_next = level_count;
    gain_next  = gain;
    ramp_next  = ramp_left;
    gain_sum   = {1'b0, gain} + {1'b0, cfg.attack_step};
    level_ext  = '0;
    hold_ext   = signed'(ang_pkg::LVL_CMP_W'(cfg.hold_count));

    if (phase == ang_pkg::PH_OPENING || phase == ang_pkg::PH_CLOSING) begin
      // Ramp step with saturation at unity and zero.
      if (phase == ang_pkg::PH_OPENING) begin
        gain_next = (gain_sum > {1'b0, ang_pkg::UNITY_GAIN})
                  ? ang_pkg::UNITY_GAIN : gain_sum[ang_pkg::GAIN_W-1:0];
      end else begin
        gain_next = (gain > cfg.decay_step) ? gain - cfg.decay_step : '0;
      end
      if (ramp_left <= ang_pkg::FRAMES_W'(1)) begin
        ramp_next  = '0;
        level_next = '0;
        if (phase == ang_pkg::PH_OPENING) begin
          phase_next = ang_pkg::PH_OPEN;
          gain_next  = ang_pkg::UNITY_GAIN;
        end else begin
          phase_next = ang_pkg::PH_CLOSED;
          gain_next  = '0;
        end
      end else begin
        ramp_next = ramp_left - ang_pkg::FRAMES_W'(1);
      end
    end else begin
      // Saturating level counter.
      if (above) begin
        if (level_count < ang_pkg::LEVEL_MAX)
          level_next = level_count + signed'(ang_pkg::LEVEL_W'(1));
      end else begin
        if (level_count > ang_pkg::LEVEL_MIN)
          level_next = level_count - signed'(ang_pkg::LEVEL_W'(1));
      end
      level_ext = ang_pkg::LVL_CMP_W'(level_next);
      if (phase == ang_pkg::PH_OPEN && level_ext < -hold_ext) begin
        ramp_next  = cfg.decay_frames;
        phase_next = ang_pkg::PH_CLOSING;
      end else if (phase == ang_pkg::PH_CLOSED && level_ext > hold_ext) begin
        ramp_next  = cfg.attack_frames;
        phase_next = ang_pkg::PH_OPENING;
      end
    end
  end

  // Channel position within the frame, with the count clamped to 1..MAX_CHANNELS.
  always_comb begin
    if (cfg.channel_count == '0) begin
      chans = ang_pkg::CH_CMP_W'(1);
    end else if (ang_pkg::CH_CMP_W'(cfg.channel_count) > ang_pkg::CH_CMP_W'(ang_pkg::MAX_CHANNELS)) begin
      chans = ang_pkg::CH_CMP_W'(ang_pkg::MAX_CHANNELS);
    end else begin
      chans = ang_pkg::CH_CMP_W'(cfg.channel_count);
    end
    pos_inc = ang_pkg::CH_CMP_W'(channel_pos) + ang_pkg::CH_CMP_W'(1);
    channel_pos_next = (pos_inc >= chans) ? '0 : pos_inc[ang_pkg::CH_POS_W-1:0];
  end

  // Gate state advances on every accepted first-channel request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ang_pkg::PH_CLOSED;
      level_count <= '0;
      gain        <= '0;
      ramp_left   <= '0;
      channel_pos <= '0;
    end else if (accept) begin
      channel_pos <= channel_pos_next;
      if (channel_pos == '0) begin
        phase       <= phase_next;
        level_count <= level_next;
        gain        <= gain_next;
        ramp_left   <= ramp_next;
      end
    end
  end

  // Stage register: the sample with the gain and phase that apply to it.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept) begin
      stage.valid <= 1'b1;
    end else if (down_ready) begin
      stage.valid <= 1'b0;
    end
    if (accept) begin
      stage.sample <= sample_in;
      stage.gain   <= (channel_pos == '0) ? gain_next : gain;
      stage.phase  <= (channel_pos == '0) ? phase_next : phase;
    end
  end

endmodule

// ===== design/ang_scale.sv =====
module ang_scale (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ang_pkg::ang_stage_t                     stage,
  output logic                                    ready,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ang_pkg::SAMPLE_WIDTH-1:0] sample_out,
  output logic [1:0]                              gate_phase
);

  logic signed [ang_pkg::PROD_W-1:0] prod;

  // Output register frees up when empty or when its request is taken.
  assign ready = !out_valid || !out_stall;

  // Signed sample times unsigned Q1.16 gain; the select is a floor shift.
  assign prod = ang_pkg::PROD_W'(stage.sample) * signed'({1'b0, stage.gain});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && stage.valid) begin
      sample_out <= prod[ang_pkg::SAMPLE_WIDTH+ang_pkg::GAIN_FRAC-1:ang_pkg::GAIN_FRAC];
      gate_phase <= 2'(stage.phase);
    end
  end

endmodule
